// File: design/lrtb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED ring blur package
// Shared constants, types and the fixed-point divide used by the ring blur.
// ----------------------------------------------------------------------------
package lrtb_pkg;

  localparam int LED_COUNT = 64;
  localparam int ADDR_W    = $clog2(LED_COUNT);
  localparam int PIX_W     = 6;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int WEIGHT_W  = 9;
  localparam int SUM_W     = 10;
  localparam int PROD_W    = WEIGHT_W + SUM_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd332;

  // floor(p / 1000) == (p * RECIP) >> RECIP_SHIFT for every p below 493447,
  // which covers the largest product 511 * 765.
  localparam int RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP = 19'd268436;
  localparam int RECIP_SHIFT = 28;
  localparam int FULL_W      = PROD_W + RECIP_W;
  localparam int QUO_W       = FULL_W - RECIP_SHIFT;
  localparam logic [QUO_W-1:0] CH_MAX = QUO_W'(255);

  // Feed sequence: one extra read ahead of the ring plus one injected copy.
  localparam int FEED_W = $clog2(LED_COUNT + 3);
  localparam logic [FEED_W-1:0] FEED_INJECT = FEED_W'(LED_COUNT + 1);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_BLUR  = 1'b1;

  typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    rgb_t              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [CH_W-1:0] blur_scale(input logic [PROD_W-1:0] prod);
    logic [FULL_W-1:0] full;
    logic [QUO_W-1:0]  quo;
    full = FULL_W'(prod) * FULL_W'(RECIP);
    quo  = QUO_W'(full >> RECIP_SHIFT);
    if (quo > CH_MAX) begin
      return {CH_W{1'b1}};
    end else begin
      return CH_W'(quo);
    end
  endfunction

endpackage

// File: design/lrtb_pixel_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED ring pixel memory
// One write and one registered read per cycle; entries never written read
// as black through per-entry valid flags cleared by reset.
// ----------------------------------------------------------------------------
module lrtb_pixel_ram
  import lrtb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ram_req_t req_i,
  output rgb_t     rdata_o
);

  rgb_t                 mem [LED_COUNT];
  logic [LED_COUNT-1:0] vld_q;
  rgb_t                 rd_data_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_data_q : '0;

endmodule

// File: design/led_ring_three_tap_blur_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED ring three-tap blur unit
// Stores a ring of RGB pixels and applies a wrapped three-tap box blur.
// ----------------------------------------------------------------------------
// A pixel write produces no output. A blur step keeps the unit busy from the
// input transfer to the transfer of the last pixel, and longer while the
// output is held off. The busy time is set by the single read port of the
// pixel memory, which streams one pixel per cycle into a three-pixel window
// while the output is not held off, preceded by one read of the last pixel
// and followed by one injected copy of the original first pixel, and by the
// pipeline of sum-multiply, reciprocal divide and output register. The input
// is not ready while a blur step is in progress. The blend weight may be
// written at any idle time; weights above 333 saturate each channel at 255.
// ----------------------------------------------------------------------------
module led_ring_three_tap_blur_unit
  import lrtb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WEIGHT_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [PIX_W-1:0]    pixel_index_i,
  input  logic [CH_W-1:0]     red_in_i,
  input  logic [CH_W-1:0]     green_in_i,
  input  logic [CH_W-1:0]     blue_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PIX_W-1:0]    out_index_o,
  output logic [CH_W-1:0]     red_out_o,
  output logic [CH_W-1:0]     green_out_o,
  output logic [CH_W-1:0]     blue_out_o,
  output logic                last_pixel_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [WEIGHT_W-1:0] weight_q;

  // Feed sequencer and memory read stage.
  logic [FEED_W-1:0] feed_q;
  logic              feeding;
  logic              inject;
  logic              v1_q;
  logic              inj_q;

  // Window stage.
  logic [1:0]        sh_q;
  logic [ADDR_W-1:0] pixcnt_q;
  rgb_t              win_q [3];
  rgb_t              s0_q;
  rgb_t              tap_value;
  logic              wv_q;
  logic [ADDR_W-1:0] pix2_q;

  // Multiply stage.
  logic              v3_q;
  logic [PROD_W-1:0] prod_q [NUM_CH];
  logic [PROD_W-1:0] prod_d [NUM_CH];
  logic [ADDR_W-1:0] idx3_q;
  rgb_t              blurred;

  // Output register.
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_idx_q;
  rgb_t              out_pix_q;
  logic              out_last_q;

  ram_req_t          ram_req;
  rgb_t              ram_rdata;

  logic adv;
  logic in_xfer;
  logic out_xfer;
  logic pix_write;

  assign adv      = !out_valid_q || out_ready_i;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_q && out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  assign pix_write = in_xfer && (action_i == ACT_WRITE) &&
                     ({1'b0, pixel_index_i} < (PIX_W + 1)'(LED_COUNT));

  assign feeding = (state_q == ST_RUN) && (feed_q <= FEED_INJECT);
  assign inject  = (feed_q == FEED_INJECT);

  always_comb begin
    ram_req    = '0;
    ram_req.re = adv && feeding && !inject;
    // The last pixel is read first so the window starts with its left side.
    if (feed_q == '0) begin
      ram_req.raddr = ADDR_W'(LED_COUNT - 1);
    end else begin
      ram_req.raddr = ADDR_W'(feed_q - FEED_W'(1));
    end
    if (state_q == ST_IDLE) begin
      ram_req.we    = pix_write;
      ram_req.waddr = ADDR_W'(pixel_index_i);
      ram_req.wdata = {blue_in_i, green_in_i, red_in_i};
    end else begin
      ram_req.we    = adv && v3_q;
      ram_req.waddr = idx3_q;
      ram_req.wdata = blurred;
    end
  end

  lrtb_pixel_ram u_pixel_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Pixel 0 is overwritten before the last pixel is blurred, so its original
  // value is kept and shifted in as the last pixel's right neighbor.
  assign tap_value = inj_q ? s0_q : ram_rdata;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod_d[c] = PROD_W'(weight_q) *
                  (PROD_W'(win_q[0][c]) + PROD_W'(win_q[1][c]) + PROD_W'(win_q[2][c]));
    end
    for (int c = 0; c < NUM_CH; c++) begin
      blurred[c] = blur_scale(prod_q[c]);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (action_i == ACT_BLUR)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_xfer && out_last_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      weight_q    <= WEIGHT_RESET;
      feed_q      <= '0;
      v1_q        <= 1'b0;
      inj_q       <= 1'b0;
      sh_q        <= '0;
      pixcnt_q    <= '0;
      wv_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        weight_q <= cfg_wdata_i;
      end
      if (state_q == ST_IDLE) begin
        feed_q   <= '0;
        sh_q     <= '0;
        pixcnt_q <= '0;
      end else if (adv) begin
        if (feeding) begin
          feed_q <= feed_q + FEED_W'(1);
        end
        if (v1_q && (sh_q == 2'd2)) begin
          pixcnt_q <= pixcnt_q + ADDR_W'(1);
        end else if (v1_q) begin
          sh_q <= sh_q + 2'd1;
        end
      end
      if (adv) begin
        v1_q        <= feeding;
        inj_q       <= feeding && inject;
        wv_q        <= v1_q && (sh_q == 2'd2);
        v3_q        <= wv_q;
        out_valid_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      win_q[2] <= win_q[1];
      win_q[1] <= win_q[0];
      win_q[0] <= tap_value;
      pix2_q   <= pixcnt_q;
      if (sh_q == 2'd1) begin
        s0_q <= tap_value;
      end
    end
    if (adv) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod_q[c] <= prod_d[c];
      end
      idx3_q <= pix2_q;
    end
    if (adv && v3_q) begin
      out_idx_q  <= idx3_q;
      out_pix_q  <= blurred;
      out_last_q <= (idx3_q == ADDR_W'(LED_COUNT - 1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = PIX_W'(out_idx_q);
  assign red_out_o    = out_pix_q[0];
  assign green_out_o  = out_pix_q[1];
  assign blue_out_o   = out_pix_q[2];
  assign last_pixel_o = out_last_q;

endmodule

// File: design/lrtb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED ring blur port checker
// Watches the ports of the blur unit for sequencing errors.
// ----------------------------------------------------------------------------
module lrtb_checker
  import lrtb_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                action_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [PIX_W-1:0]    out_index_o,
  input logic [CH_W-1:0]     red_out_o,
  input logic [CH_W-1:0]     green_out_o,
  input logic [CH_W-1:0]     blue_out_o,
  input logic                last_pixel_o
);

  // A result waiting for transfer holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_index_o) &&
      $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o) &&
      $stable(last_pixel_o))
    else $error("output result changed while stalled");

  // Results only appear while a blur step occupies the unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result is pending");

  // Once a blur step is accepted, the input is closed in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_BLUR) |=> !in_ready_o)
    else $error("input ready right after a blur transfer");

  // A pixel write completes at once and produces nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_WRITE) |=> in_ready_o && !out_valid_o)
    else $error("pixel write stalled the unit or produced a result");

  // The unit reopens right after the last pixel of a blur transfers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_pixel_o |=> in_ready_o && !out_valid_o)
    else $error("unit did not return to idle after the last pixel");

endmodule

bind led_ring_three_tap_blur_unit lrtb_checker u_lrtb_checker (.*);
